// File: hdl/a4v_pkg.sv
// ----------------------------------------------------------------------------
// a4v_pkg
// Types, constants and fixed tables shared by the four-voice ADPCM player.
// ----------------------------------------------------------------------------
package a4v_pkg;

  localparam int CommandWidth = 2;
  localparam int DataWidth    = 8;
  localparam int AddressWidth = 18;
  localparam int MixOutWidth  = 28;
  localparam int BusyWidth    = 4;
  localparam int MasterWidth  = 10;
  localparam int RateWidth    = 15;
  localparam int MixWidth     = 18;
  localparam int SampleWidth  = 12;
  localparam int GainWidth    = 9;
  localparam int StepIdxWidth = 6;
  localparam int StepMax      = 48;
  localparam int SampleMaxVal = 2047;
  localparam int SampleMinVal = -2048;

  localparam logic [CommandWidth-1:0] CMD_BYTE = 2'd0;
  localparam logic [CommandWidth-1:0] CMD_TICK = 2'd1;
  localparam logic [CommandWidth-1:0] CMD_LOAD = 2'd2;

  localparam logic [0:0] REG_MASTER_VOLUME = 1'b0;
  localparam logic [0:0] REG_RATE_STEP     = 1'b1;

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_TICK,
    KIND_LOAD
  } item_kind_t;

  typedef struct packed {
    item_kind_t              kind;
    logic [DataWidth-1:0]    data;
    logic [AddressWidth-1:0] addr;
  } queue_item_t;

  function automatic logic [10:0] step_size(input logic [StepIdxWidth-1:0] idx);
    logic [10:0] s;
    case (idx)
      6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;   6'd3:  s = 11'd21;
      6'd4:  s = 11'd23;   6'd5:  s = 11'd25;   6'd6:  s = 11'd28;   6'd7:  s = 11'd31;
      6'd8:  s = 11'd34;   6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
      6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;   6'd15: s = 11'd66;
      6'd16: s = 11'd73;   6'd17: s = 11'd80;   6'd18: s = 11'd88;   6'd19: s = 11'd97;
      6'd20: s = 11'd107;  6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
      6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;  6'd27: s = 11'd209;
      6'd28: s = 11'd230;  6'd29: s = 11'd253;  6'd30: s = 11'd279;  6'd31: s = 11'd307;
      6'd32: s = 11'd337;  6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
      6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;  6'd39: s = 11'd658;
      6'd40: s = 11'd724;  6'd41: s = 11'd796;  6'd42: s = 11'd876;  6'd43: s = 11'd963;
      6'd44: s = 11'd1060; 6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
      6'd48: s = 11'd1552;
      default: s = 11'd1552;
    endcase
    return s;
  endfunction

  function automatic logic [GainWidth-1:0] gain_level(input logic [3:0] idx);
    logic [GainWidth-1:0] g;
    case (idx)
      4'd0:  g = 9'd256; 4'd1:  g = 9'd181; 4'd2:  g = 9'd128; 4'd3:  g = 9'd91;
      4'd4:  g = 9'd64;  4'd5:  g = 9'd45;  4'd6:  g = 9'd32;  4'd7:  g = 9'd23;
      4'd8:  g = 9'd16;  4'd9:  g = 9'd11;  4'd10: g = 9'd8;   4'd11: g = 9'd6;
      4'd12: g = 9'd4;   4'd13: g = 9'd3;   4'd14: g = 9'd2;   4'd15: g = 9'd1;
      default: g = 9'd1;
    endcase
    return g;
  endfunction

  function automatic logic signed [4:0] step_adjust(input logic [2:0] code);
    logic signed [4:0] a;
    case (code)
      3'd4:    a = 5'sd2;
      3'd5:    a = 5'sd4;
      3'd6:    a = 5'sd6;
      3'd7:    a = 5'sd8;
      default: a = -5'sd1;
    endcase
    return a;
  endfunction

endpackage

// File: hdl/a4v_ifs.sv
// ----------------------------------------------------------------------------
// a4v interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface a4v_item_if import a4v_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CommandWidth-1:0] command;
  logic [DataWidth-1:0]    data_byte;
  logic [AddressWidth-1:0] rom_address;
  modport source (output valid, command, data_byte, rom_address, input ready);
  modport sink   (input valid, command, data_byte, rom_address, output ready);
endinterface

interface a4v_result_if import a4v_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [MixOutWidth-1:0] mixed_sample;
  logic [BusyWidth-1:0]          channel_busy;
  modport source (output valid, mixed_sample, channel_busy, input ready);
  modport sink   (input valid, mixed_sample, channel_busy, output ready);
endinterface

interface a4v_cfg_if import a4v_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [0:0]           reg_index;
  logic [RateWidth-1:0] write_data;
  modport source (output valid, reg_index, write_data, input ready);
  modport sink   (input valid, reg_index, write_data, output ready);
endinterface

// File: hdl/a4v_front.sv
// ----------------------------------------------------------------------------
// a4v_front
// Accepts input items, classifies the command and queues them (two deep).
// ----------------------------------------------------------------------------
module a4v_front import a4v_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  a4v_item_if.sink    items,
  output logic        q_valid,
  output queue_item_t q_item,
  input  logic        q_ready
);

  queue_item_t slot [2];
  logic [1:0]  count;
  logic        push;
  logic        pop;
  logic        known;
  queue_item_t incoming;

  assign items.ready = (count != 2'd2);
  assign q_valid     = (count != 2'd0);
  assign q_item      = slot[0];
  assign pop         = q_valid && q_ready;

  always_comb begin
    known         = 1'b1;
    incoming.data = items.data_byte;
    incoming.addr = items.rom_address;
    case (items.command)
      CMD_BYTE: incoming.kind = KIND_BYTE;
      CMD_TICK: incoming.kind = KIND_TICK;
      CMD_LOAD: incoming.kind = KIND_LOAD;
      default: begin
        incoming.kind = KIND_BYTE;
        known         = 1'b0;
      end
    endcase
  end

  // Unknown commands are taken and dropped here.
  assign push = items.valid && items.ready && known;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      slot[0] <= incoming;
    end else if (pop) begin
      slot[0] <= slot[1];
    end
    if (push && !(count == 2'd0 || (count == 2'd1 && pop))) begin
      slot[1] <= incoming;
    end
  end

endmodule

// File: hdl/a4v_back.sv
// ----------------------------------------------------------------------------
// a4v_back
// Sequencer that runs queued items: ROM writes, command bytes, decode rounds
// with one shared ADPCM unit, interpolation and the master volume product.
// ----------------------------------------------------------------------------
module a4v_back import a4v_pkg::*; #(
  parameter int ROM_ADDRESS_BITS = 18,
  parameter int VOICES           = 4,
  parameter int FRACTION_BITS    = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  queue_item_t       q_item,
  output logic              q_ready,
  input  logic [MasterWidth-1:0] master_volume,
  input  logic [RateWidth-1:0]   rate_step,
  a4v_result_if.source      result
);

  localparam int RAB  = ROM_ADDRESS_BITS;
  localparam int NAB  = RAB + 1;
  localparam int NLB  = RAB + 2;
  localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int FW   = ((FRACTION_BITS > RateWidth) ? FRACTION_BITS : RateWidth) + 1;
  localparam int DW   = MixWidth + 1;
  localparam int PIW  = DW + FRACTION_BITS + 1;
  localparam int POW  = DW + MasterWidth + 1;
  localparam logic [FW-1:0] FracUnit = FW'(1) << FRACTION_BITS;
  localparam logic [VW-1:0] LastVoice = VW'(VOICES - 1);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PT_ADDR  = 4'd1;
  localparam logic [3:0] S_PT_DATA  = 4'd2;
  localparam logic [3:0] S_START    = 4'd3;
  localparam logic [3:0] S_VOICE    = 4'd4;
  localparam logic [3:0] S_ROM_WAIT = 4'd5;
  localparam logic [3:0] S_COMPUTE  = 4'd6;
  localparam logic [3:0] S_ACC      = 4'd7;
  localparam logic [3:0] S_ROUND    = 4'd8;
  localparam logic [3:0] S_INT_MUL  = 4'd9;
  localparam logic [3:0] S_INT_ADD  = 4'd10;
  localparam logic [3:0] S_VOL_MUL  = 4'd11;
  localparam logic [3:0] S_EMIT     = 4'd12;

  logic [3:0] state;

  logic [7:0]     rom [2**RAB];
  logic [7:0]     rom_q;
  logic [RAB-1:0] rom_raddr;
  logic           rom_we;

  logic [VOICES-1:0] busy;
  logic              pending;
  logic [9:0]        pt_addr;
  logic [2:0]        pt_count;
  logic [47:0]       pt_bytes;
  logic [3:0]        sel;
  logic [3:0]        vol;
  logic [VW-1:0]     vsel;

  logic [GainWidth-1:0]           gain     [VOICES];
  logic signed [SampleWidth-1:0]  sample   [VOICES];
  logic [NAB-1:0]                 nib_addr [VOICES];
  logic [NLB-1:0]                 left     [VOICES];
  logic [StepIdxWidth-1:0]        step_idx [VOICES];
  logic [7:0]                     latched  [VOICES];

  logic [VW-1:0]                  vidx;
  logic [3:0]                     nib;
  logic signed [21:0]             product;
  logic signed [MixWidth-1:0]     mix;
  logic signed [MixWidth-1:0]     prev_mix;
  logic signed [MixWidth-1:0]     cur_mix;
  logic [FW-1:0]                  frac;
  logic signed [PIW-1:0]          prod_i;
  logic signed [DW-1:0]           interp;
  logic signed [POW-1:0]          prod_o;

  logic                           out_valid;
  logic signed [MixOutWidth-1:0]  out_sample;
  logic [BusyWidth-1:0]           out_busy;
  logic                           emit;

  logic [RAB-1:0] start_a;
  logic [RAB-1:0] stop_a;
  logic [10:0]    s;
  logic [12:0]    delta;
  logic signed [13:0] smp_sum;
  logic signed [SampleWidth-1:0] smp_new;
  logic signed [7:0] st_sum;
  logic [StepIdxWidth-1:0] st_new;
  logic [FW-1:0]  frac_less;
  logic           sel_ok;
  logic [VW-1:0]  sel_voice;

  assign q_ready = (state == S_IDLE);
  assign rom_we  = (state == S_IDLE) && q_valid && (q_item.kind == KIND_LOAD);
  assign emit    = (state == S_EMIT) && (!out_valid || result.ready);

  always_comb begin
    rom_raddr = nib_addr[vidx][NAB-1:1];
    if (state == S_PT_ADDR) begin
      rom_raddr = RAB'(pt_addr) + RAB'(pt_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rom_we) begin
      rom[RAB'(q_item.addr)] <= q_item.data;
    end
    rom_q <= rom[rom_raddr];
  end

  assign start_a = pt_bytes[24 +: RAB];
  assign stop_a  = pt_bytes[0 +: RAB];

  always_comb begin
    sel_voice = '0;
    case (q_item.data[7:4])
      4'd1:    sel_voice = VW'(0);
      4'd2:    sel_voice = VW'(1);
      4'd4:    sel_voice = VW'(2);
      4'd8:    sel_voice = VW'(3);
      default: sel_voice = '0;
    endcase
    sel_ok = $onehot(q_item.data[7:4]) &&
             ((q_item.data[7:4] & 4'(2**VOICES - 1)) != 4'd0);
  end

  // Shared ADPCM step for the voice in hand.
  always_comb begin
    s     = step_size(step_idx[vidx]);
    delta = 13'(s >> 3);
    if (nib[0]) delta = delta + 13'(s >> 2);
    if (nib[1]) delta = delta + 13'(s >> 1);
    if (nib[2]) delta = delta + 13'(s);
    if (nib[3]) begin
      smp_sum = 14'(sample[vidx]) - $signed({1'b0, delta});
    end else begin
      smp_sum = 14'(sample[vidx]) + $signed({1'b0, delta});
    end
    if (smp_sum > 14'(SampleMaxVal)) smp_new = 12'(SampleMaxVal);
    else if (smp_sum < 14'(SampleMinVal)) smp_new = 12'(SampleMinVal);
    else smp_new = smp_sum[SampleWidth-1:0];
    st_sum = $signed({2'b00, step_idx[vidx]}) + 8'(step_adjust(nib[2:0]));
    if (st_sum > 8'sd48) st_new = 6'(StepMax);
    else if (st_sum < 8'sd0) st_new = '0;
    else st_new = st_sum[StepIdxWidth-1:0];
    frac_less = frac - FracUnit;
  end

  assign result.valid        = out_valid;
  assign result.mixed_sample = out_sample;
  assign result.channel_busy = out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      busy      <= '0;
      pending   <= 1'b0;
      pt_addr   <= '0;
      prev_mix  <= '0;
      cur_mix   <= '0;
      frac      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && result.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            case (q_item.kind)
              KIND_BYTE: begin
                if (pending) begin
                  pending <= 1'b0;
                  sel     <= q_item.data[7:4];
                  vol     <= q_item.data[3:0];
                  vsel    <= sel_voice;
                  if (sel_ok) begin
                    pt_count <= 3'd0;
                    state    <= S_PT_ADDR;
                  end
                end else if (q_item.data[7]) begin
                  pt_addr <= {q_item.data[6:0], 3'b000};
                  pending <= 1'b1;
                end else begin
                  busy <= busy & ~VOICES'(q_item.data[6:3]);
                end
              end
              KIND_TICK: begin
                if (frac >= FracUnit) begin
                  prev_mix <= cur_mix;
                  mix      <= '0;
                  vidx     <= '0;
                  state    <= S_VOICE;
                end else begin
                  state <= S_INT_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        S_PT_ADDR: state <= S_PT_DATA;
        S_PT_DATA: begin
          pt_bytes <= {pt_bytes[39:0], rom_q};
          if (pt_count == 3'd5) begin
            state <= S_START;
          end else begin
            pt_count <= pt_count + 3'd1;
            state    <= S_PT_ADDR;
          end
        end
        S_START: begin
          if (start_a < stop_a) begin
            if ((busy & VOICES'(sel)) == '0) begin
              busy           <= busy | VOICES'(sel);
              gain[vsel]     <= gain_level(vol);
              nib_addr[vsel] <= {start_a, 1'b0};
              left[vsel]     <= {NLB'({1'b0, stop_a - start_a}) + NLB'(1)} << 1;
              step_idx[vsel] <= '0;
              sample[vsel]   <= -12'sd2;
            end
          end else begin
            busy <= busy & ~VOICES'(sel);
          end
          state <= S_IDLE;
        end
        S_VOICE: begin
          if (!busy[vidx] || left[vidx] == '0) begin
            busy[vidx] <= 1'b0;
            if (vidx == LastVoice) state <= S_ROUND;
            else vidx <= vidx + VW'(1);
          end else begin
            left[vidx] <= left[vidx] - NLB'(1);
            if (nib_addr[vidx][0]) begin
              nib   <= latched[vidx][3:0];
              state <= S_COMPUTE;
            end else begin
              state <= S_ROM_WAIT;
            end
          end
        end
        S_ROM_WAIT: begin
          latched[vidx] <= rom_q;
          nib           <= rom_q[7:4];
          state         <= S_COMPUTE;
        end
        S_COMPUTE: begin
          sample[vidx]   <= smp_new;
          step_idx[vidx] <= st_new;
          nib_addr[vidx] <= nib_addr[vidx] + NAB'(1);
          product        <= 22'(smp_new) * $signed({1'b0, gain[vidx]});
          state          <= S_ACC;
        end
        S_ACC: begin
          mix <= mix + MixWidth'(product >>> 4);
          if (vidx == LastVoice) state <= S_ROUND;
          else begin
            vidx  <= vidx + VW'(1);
            state <= S_VOICE;
          end
        end
        S_ROUND: begin
          cur_mix <= mix;
          frac    <= frac_less;
          if (frac_less >= FracUnit) begin
            mix   <= '0;
            vidx  <= '0;
            state <= S_VOICE;
          end else begin
            state <= S_INT_MUL;
          end
        end
        S_INT_MUL: begin
          prod_i <= PIW'(DW'(cur_mix) - DW'(prev_mix)) *
                    $signed({1'b0, frac[FRACTION_BITS-1:0]});
          state  <= S_INT_ADD;
        end
        S_INT_ADD: begin
          interp <= DW'(prev_mix) + DW'(prod_i >>> FRACTION_BITS);
          state  <= S_VOL_MUL;
        end
        S_VOL_MUL: begin
          prod_o <= POW'(interp) * $signed({1'b0, master_volume});
          state  <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            out_sample <= prod_o[MixOutWidth-1:0];
            out_busy   <= BusyWidth'(busy);
            frac       <= frac + FW'(rate_step);
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: hdl/adpcm_four_voice_sample_player_top.sv
// ----------------------------------------------------------------------------
// adpcm_four_voice_sample_player_top
// Four-voice ADPCM phrase player with a loadable phrase ROM.
// ----------------------------------------------------------------------------
// Requests arrive on requests: command bytes, output ticks and ROM byte
// loads. Only a tick produces a result on results: the interpolated voice
// mix times master volume, with the busy bit of each voice.
// Register writes (master volume, rate step) arrive on cfg and are always
// taken; write them only while the block is idle.
// A two-deep queue sits in front of the sequencer. A phrase lookup by a
// command byte reads six bytes from the ROM. A tick runs up to eight
// decode rounds of four voices; each round skips idle voices, reads a
// new ROM byte for a playing voice when it needs one, then decodes and
// accumulates. The tick then interpolates and applies master volume.
// The sequencer has a single ROM read port and a shared ADPCM unit.
// A held result waits in the output register while the next item is already
// being worked on; the sequencer waits only when a second result is ready.
// Reset clears the voices, the command state, the mixes and the fraction,
// and sets the registers to their defaults; the ROM keeps its contents.
// ----------------------------------------------------------------------------
module adpcm_four_voice_sample_player_top import a4v_pkg::*; #(
  parameter int ROM_ADDRESS_BITS = 18,
  parameter int VOICES           = 4,
  parameter int FRACTION_BITS    = 12
) (
  input logic          clk,
  input logic          rst,
  a4v_item_if.sink     requests,
  a4v_result_if.source results,
  a4v_cfg_if.sink      cfg
);

  logic                   q_valid;
  logic                   q_ready;
  queue_item_t            q_item;
  logic [MasterWidth-1:0] master_volume;
  logic [RateWidth-1:0]   rate_step;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume <= MasterWidth'(256);
      rate_step     <= RateWidth'(703);
    end else if (cfg.valid) begin
      case (cfg.reg_index)
        REG_MASTER_VOLUME: master_volume <= cfg.write_data[MasterWidth-1:0];
        REG_RATE_STEP:     rate_step     <= cfg.write_data;
        default: ;
      endcase
    end
  end

  a4v_front u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (requests),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_ready (q_ready)
  );

  a4v_back #(
    .ROM_ADDRESS_BITS (ROM_ADDRESS_BITS),
    .VOICES           (VOICES),
    .FRACTION_BITS    (FRACTION_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_ready       (q_ready),
    .master_volume (master_volume),
    .rate_step     (rate_step),
    .result        (results)
  );

endmodule
